[hdl/ffcd_pkg.sv]
package ffcd_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] POS_ZERO  = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
	localparam logic [31:0] POS_INF   = 32'h7F80_0000;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 32;

	localparam logic [CFG_AW-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_SIGMA = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MASK  = 2'd2;

	typedef enum logic [1:0] {
		MODE_DRIFT    = 2'd0,
		MODE_PARALLEL = 2'd1,
		MODE_TOTAL    = 2'd2,
		MODE_STIFF    = 2'd3
	} mode_t;

	// divider: quotient bits, bits per stage, register stages (setup + iterations + round)
	localparam int DIV_QBITS = 26;
	localparam int DIV_STEP  = 2;
	localparam int DIV_ITERS = DIV_QBITS / DIV_STEP;
	localparam int DIV_LAT   = DIV_ITERS + 2;

	// register stages from accepted request to result strobe
	localparam int PIPE_LAT  = DIV_LAT + 9;
	localparam int ACC_DLY   = DIV_LAT - 5;

	// drift terms: E_low index, B_low index, negated charge
	localparam logic [1:0] DJ [6] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};
	localparam logic [1:0] DK [6] = '{2'd2, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
	localparam logic [5:0] DNEG   = 6'b100110;

	typedef struct packed {
		logic [31:0] charge_density;
		logic [31:0] e_x;
		logic [31:0] e_y;
		logic [31:0] e_z;
		logic [31:0] b_x;
		logic [31:0] b_y;
		logic [31:0] b_z;
		logic [63:0] lapse_and_volume;
		logic [63:0] metric_xx_xy;
		logic [63:0] metric_xz_yy;
		logic [63:0] metric_yz_zz;
		logic        interior_flag;
	} req_t;

	typedef struct packed {
		logic [31:0] j_x;
		logic [31:0] j_y;
		logic [31:0] j_z;
	} rsp_t;

	typedef struct packed {
		logic               spec;
		logic [31:0]        spec_val;
		logic               sgn;
		logic signed [11:0] be;
		logic [23:0]        den;
	} div_ctl_t;

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] a);
		return a[30:0] == 31'd0;
	endfunction

	function automatic logic is_pos(input logic [31:0] a);
		return !a[31] && !is_zero(a) && !is_nan(a);
	endfunction

	function automatic logic [31:0] fneg(input logic [31:0] a);
		return {~a[31], a[30:0]};
	endfunction

	function automatic logic [5:0] lzc51(input logic [50:0] v);
		logic [5:0] n;
		n = 6'd51;
		for (int i = 0; i < 51; i++) begin
			if (v[i]) n = 6'(50 - i);
		end
		return n;
	endfunction

	// sig: leading one at bit 50 (value 1.x * 2^(be-127)), st: bits below sig
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] be,
			input logic [50:0] sig, input logic st_in);
		logic [6:0]  sh;
		logic [50:0] v;
		logic        lost;
		logic [23:0] m;
		logic        g;
		logic        st;
		logic [30:0] pk;
		logic [30:0] r;
		if (be >= 12'sd255) return {s, POS_INF[30:0]};
		if (be < 12'sd1) begin
			sh = (be < -12'sd60) ? 7'd62 : 7'(12'sd1 - be);
		end else begin
			sh = 7'd0;
		end
		v    = sig >> sh;
		lost = |(sig & ~({51{1'b1}} << sh));
		m    = v[50:27];
		g    = v[26];
		st   = st_in | lost | (|v[25:0]);
		pk   = (be < 12'sd1) ? {8'd0, m[22:0]} : {be[7:0], m[22:0]};
		r    = pk + 31'(g & (st | m[0]));
		return {s, r};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic               s;
		logic [23:0]        ma;
		logic [23:0]        mb;
		logic signed [11:0] ea;
		logic signed [11:0] eb;
		logic [47:0]        p;
		logic [5:0]         lz;
		logic [50:0]        sig;
		logic signed [11:0] be;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b)) return CANON_NAN;
		if (is_inf(a) || is_inf(b)) begin
			return (is_zero(a) || is_zero(b)) ? CANON_NAN : {s, POS_INF[30:0]};
		end
		if (is_zero(a) || is_zero(b)) return {s, 31'd0};
		ma  = {a[30:23] != 8'd0, a[22:0]};
		mb  = {b[30:23] != 8'd0, b[22:0]};
		ea  = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
		eb  = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
		p   = ma * mb;
		lz  = lzc51({p, 3'b000});
		sig = {p, 3'b000} << lz;
		be  = ea + eb - 12'sd126 - $signed({6'd0, lz});
		return round_pack(s, be, sig, 1'b0);
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [23:0] mx;
		logic [23:0] my;
		logic [8:0]  ex;
		logic [8:0]  ey;
		logic [7:0]  d;
		logic [50:0] xf;
		logic [50:0] yf;
		logic [50:0] ys;
		logic [50:0] sm;
		logic [5:0]  lz;
		logic signed [11:0] be;
		if (is_nan(a) || is_nan(b)) return CANON_NAN;
		if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		mx = {x[30:23] != 8'd0, x[22:0]};
		my = {y[30:23] != 8'd0, y[22:0]};
		ex = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
		ey = (y[30:23] == 8'd0) ? 9'd1 : {1'b0, y[30:23]};
		d  = 8'(ex - ey);
		xf = {1'b0, mx, 26'd0};
		yf = {1'b0, my, 26'd0};
		ys = yf >> d;
		ys[0] = ys[0] | (|(yf & ~({51{1'b1}} << d)));
		sm = (x[31] == y[31]) ? xf + ys : xf - ys;
		if (sm == 51'd0) return {x[31] & y[31], 31'd0};
		lz = lzc51(sm);
		be = $signed({3'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
		return round_pack(x[31], be, sm << lz, 1'b0);
	endfunction

endpackage

[hdl/ffcd_delay.sv]
module ffcd_delay
	import ffcd_pkg::*;
#(
	parameter int W = 32,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [D];

	always_ff @(posedge clk) begin
		tap_s[0] <= d;
		for (int i = 1; i < D; i++) begin
			tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[D-1];

endmodule

[hdl/ffcd_div.sv]
module ffcd_div
	import ffcd_pkg::*;
(
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] q
);

	div_ctl_t    ctl_s [DIV_ITERS+1];
	logic [25:0] rem_s [DIV_ITERS+1];
	logic [25:0] quo_s [DIV_ITERS+1];
	logic [31:0] q_s;

	div_ctl_t           ctl0;
	logic [23:0]        ma;
	logic [23:0]        mb;
	logic [23:0]        na;
	logic [23:0]        nb;
	logic signed [11:0] ea;
	logic signed [11:0] eb;
	logic [5:0]         lza;
	logic [5:0]         lzb;

	always_comb begin
		ma  = {a[30:23] != 8'd0, a[22:0]};
		mb  = {b[30:23] != 8'd0, b[22:0]};
		lza = lzc51({ma, 27'd0});
		lzb = lzc51({mb, 27'd0});
		na  = ma << lza;
		nb  = mb << lzb;
		ea  = ((a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]})) - $signed({6'd0, lza});
		eb  = ((b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]})) - $signed({6'd0, lzb});
		ctl0.sgn      = a[31] ^ b[31];
		ctl0.be       = ea - eb + 12'sd127;
		ctl0.den      = nb;
		ctl0.spec     = 1'b1;
		ctl0.spec_val = CANON_NAN;
		if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b))
				|| (is_zero(a) && is_zero(b))) begin
			ctl0.spec_val = CANON_NAN;
		end else if (is_inf(a) || is_zero(b)) begin
			ctl0.spec_val = {a[31] ^ b[31], POS_INF[30:0]};
		end else if (is_inf(b) || is_zero(a)) begin
			ctl0.spec_val = {a[31] ^ b[31], 31'd0};
		end else begin
			ctl0.spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[0] <= ctl0;
		rem_s[0] <= {2'b00, na};
		quo_s[0] <= '0;
	end

	for (genvar k = 1; k <= DIV_ITERS; k++) begin : g_iter
		logic [25:0] r;
		logic [25:0] qv;
		always_comb begin
			r  = rem_s[k-1];
			qv = quo_s[k-1];
			for (int j = 0; j < DIV_STEP; j++) begin
				if (r >= {2'b00, ctl_s[k-1].den}) begin
					r  = r - {2'b00, ctl_s[k-1].den};
					qv = {qv[24:0], 1'b1};
				end else begin
					qv = {qv[24:0], 1'b0};
				end
				r = {r[24:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			ctl_s[k] <= ctl_s[k-1];
			rem_s[k] <= r;
			quo_s[k] <= qv;
		end
	end

	div_ctl_t    cf;
	logic [25:0] qf;
	logic [50:0] sig;
	logic        lz1;

	always_comb begin
		cf  = ctl_s[DIV_ITERS];
		qf  = quo_s[DIV_ITERS];
		lz1 = ~qf[25];
		sig = qf[25] ? {qf, 25'd0} : {qf[24:0], 26'd0};
	end

	always_ff @(posedge clk) begin
		q_s <= cf.spec ? cf.spec_val
			: round_pack(cf.sgn, cf.be - $signed({11'd0, lz1}), sig,
				rem_s[DIV_ITERS] != 26'd0);
	end

	assign q = q_s;

endmodule

[hdl/force_free_current_density.sv]
// Force-free current density kernel, fully pipelined binary32 datapath.
// One request is taken every cycle (busy stays low); done is high for one
// cycle with its result on rsp as its bit leaves the vld_q shift register.
// Pipe depth is set by the 15-stage radix-4 divider chain (quotient by the
// volume factor and lapse / B^2) plus the surrounding multiply/add stages.
// Results leave in request order and cannot be held off by the receiver.
// Configuration writes take effect at once and are meant for idle periods.
module force_free_current_density
	import ffcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output logic              done,
	output rsp_t              rsp
);

	mode_t       mode_q;
	logic [31:0] sigma_q;
	logic        mask_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic        accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TOTAL;
			sigma_q <= '0;
			mask_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MODE:  mode_q  <= mode_t'(cfg_wdata[1:0]);
				REG_SIGMA: sigma_q <= cfg_wdata[31:0];
				REG_MASK:  mask_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
		end
	end

	logic par_on;
	logic drift_on;
	assign par_on   = mode_q != MODE_DRIFT;
	assign drift_on = (mode_q == MODE_DRIFT) || (mode_q == MODE_TOTAL);

	// side channels
	logic [95:0] e_d3, e_d7, b_d3, b_d6;
	logic [31:0] q_d3, vol_d5, lapse_d6;
	logic        flag_d;

	ffcd_delay #(.W(96), .D(3)) u_e3 (.clk(clk), .d({req.e_x, req.e_y, req.e_z}), .q(e_d3));
	ffcd_delay #(.W(96), .D(4)) u_e7 (.clk(clk), .d(e_d3), .q(e_d7));
	ffcd_delay #(.W(96), .D(3)) u_b3 (.clk(clk), .d({req.b_x, req.b_y, req.b_z}), .q(b_d3));
	ffcd_delay #(.W(96), .D(3)) u_b6 (.clk(clk), .d(b_d3), .q(b_d6));
	ffcd_delay #(.W(32), .D(3)) u_q3 (.clk(clk), .d(req.charge_density), .q(q_d3));
	ffcd_delay #(.W(32), .D(5)) u_v5 (.clk(clk), .d(req.lapse_and_volume[31:0]), .q(vol_d5));
	ffcd_delay #(.W(32), .D(6)) u_l6 (.clk(clk), .d(req.lapse_and_volume[63:32]), .q(lapse_d6));
	ffcd_delay #(.W(1), .D(PIPE_LAT-1)) u_fl (.clk(clk), .d(req.interior_flag), .q(flag_d));

	logic [31:0] gm [3][3];
	logic [31:0] ev [3];
	logic [31:0] bv [3];
	logic [31:0] ev3 [3];
	logic [31:0] ev7 [3];
	logic [31:0] bv3 [3];
	logic [31:0] bv6 [3];

	always_comb begin
		gm[0][0] = req.metric_xx_xy[63:32];
		gm[0][1] = req.metric_xx_xy[31:0];
		gm[0][2] = req.metric_xz_yy[63:32];
		gm[1][1] = req.metric_xz_yy[31:0];
		gm[1][2] = req.metric_yz_zz[63:32];
		gm[2][2] = req.metric_yz_zz[31:0];
		gm[1][0] = gm[0][1];
		gm[2][0] = gm[0][2];
		gm[2][1] = gm[1][2];
		ev[0] = req.e_x;
		ev[1] = req.e_y;
		ev[2] = req.e_z;
		bv[0] = req.b_x;
		bv[1] = req.b_y;
		bv[2] = req.b_z;
		for (int i = 0; i < 3; i++) begin
			ev3[i] = e_d3[95-32*i -: 32];
			ev7[i] = e_d7[95-32*i -: 32];
			bv3[i] = b_d3[95-32*i -: 32];
			bv6[i] = b_d6[95-32*i -: 32];
		end
	end

	logic [31:0] ge_s1 [3][3];
	logic [31:0] gb_s1 [3][3];
	logic [31:0] se_s2 [3];
	logic [31:0] sb_s2 [3];
	logic [31:0] ge2_s2 [3];
	logic [31:0] gb2_s2 [3];
	logic [31:0] el_s3 [3];
	logic [31:0] bl_s3 [3];
	logic [31:0] bb_s4 [3];
	logic [31:0] ee_s4 [3];
	logic [31:0] eb_s4 [3];
	logic [31:0] bl_s4 [3];
	logic [31:0] dt_s4 [6];
	logic [31:0] dt_s5 [6];
	logic [31:0] b2p_s5, e2p_s5, ebp_s5, bb2_s5, ee2_s5, eb2_s5;
	logic [31:0] b2_s6, e2_s6, eb_s6;
	logic [31:0] d_s7;
	logic [31:0] x_s7 [3];
	logic [31:0] x_s8 [3];
	logic [31:0] y_s8 [3];
	logic [31:0] s_s9 [3];
	logic [31:0] acc_s10 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ge_s1[i][j] <= fmul(gm[i][j], ev[j]);
				gb_s1[i][j] <= fmul(gm[i][j], bv[j]);
			end
			se_s2[i]  <= fadd(ge_s1[i][0], ge_s1[i][1]);
			sb_s2[i]  <= fadd(gb_s1[i][0], gb_s1[i][1]);
			ge2_s2[i] <= ge_s1[i][2];
			gb2_s2[i] <= gb_s1[i][2];
			el_s3[i]  <= fadd(se_s2[i], ge2_s2[i]);
			bl_s3[i]  <= fadd(sb_s2[i], gb2_s2[i]);
			bb_s4[i]  <= fmul(bv3[i], bl_s3[i]);
			ee_s4[i]  <= fmul(ev3[i], el_s3[i]);
			eb_s4[i]  <= fmul(ev3[i], bl_s3[i]);
			bl_s4[i]  <= bl_s3[i];
			x_s7[i]   <= fmul(eb_s6, bv6[i]);
			x_s8[i]   <= x_s7[i];
			y_s8[i]   <= fmul(is_pos(d_s7) ? d_s7 : POS_ZERO, ev7[i]);
			s_s9[i]   <= fadd(x_s8[i], y_s8[i]);
			acc_s10[i] <= par_on ? fmul(sigma_q, s_s9[i]) : POS_ZERO;
		end
		for (int k = 0; k < 6; k++) begin
			dt_s4[k] <= fmul(DNEG[k] ? fneg(q_d3) : q_d3, el_s3[DJ[k]]);
			dt_s5[k] <= fmul(dt_s4[k], bl_s4[DK[k]]);
		end
		b2p_s5 <= fadd(bb_s4[0], bb_s4[1]);
		e2p_s5 <= fadd(ee_s4[0], ee_s4[1]);
		ebp_s5 <= fadd(eb_s4[0], eb_s4[1]);
		bb2_s5 <= bb_s4[2];
		ee2_s5 <= ee_s4[2];
		eb2_s5 <= eb_s4[2];
		b2_s6  <= fadd(b2p_s5, bb2_s5);
		e2_s6  <= fadd(e2p_s5, ee2_s5);
		eb_s6  <= fadd(ebp_s5, eb2_s5);
		d_s7   <= fadd(e2_s6, fneg(b2_s6));
	end

	// dividers
	logic [31:0] tq [6];
	logic [31:0] fq;

	for (genvar k = 0; k < 6; k++) begin : g_dt
		ffcd_div u_div (.clk(clk), .a(dt_s5[k]), .b(vol_d5), .q(tq[k]));
	end

	ffcd_div u_fdiv (.clk(clk), .a(lapse_d6), .b(b2_s6), .q(fq));

	logic [95:0] acc_d;
	ffcd_delay #(.W(96), .D(ACC_DLY)) u_acc (
		.clk(clk),
		.d({acc_s10[0], acc_s10[1], acc_s10[2]}),
		.q(acc_d)
	);

	logic [31:0] a1_s21 [3];
	logic [31:0] tq_s21 [3];
	logic [31:0] a2_s22 [3];
	logic [31:0] f_s22;
	logic [31:0] r_s23 [3];
	logic [31:0] w_s24 [3];
	logic [31:0] w   [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a1_s21[i] <= drift_on ? fadd(acc_d[95-32*i -: 32], tq[2*i])
				: acc_d[95-32*i -: 32];
			tq_s21[i] <= tq[2*i+1];
			a2_s22[i] <= drift_on ? fadd(a1_s21[i], tq_s21[i]) : a1_s21[i];
			r_s23[i]  <= fmul(a2_s22[i], f_s22);
			w_s24[i]  <= w[i];
		end
		f_s22 <= fq;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w[i] = (mask_q && flag_d) ? POS_ZERO : r_s23[i];
			if (is_nan(w[i])) w[i] = CANON_NAN;
			if (mode_q == MODE_STIFF && w[i] != CANON_NAN) w[i] = fneg(w[i]);
		end
	end

	assign done    = vld_q[PIPE_LAT-1];
	assign rsp.j_x = w_s24[0];
	assign rsp.j_y = w_s24[1];
	assign rsp.j_z = w_s24[2];

	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("result strobe without matching request");

	a_canon_nan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !((is_nan(rsp.j_x) && rsp.j_x != CANON_NAN)
			|| (is_nan(rsp.j_y) && rsp.j_y != CANON_NAN)
			|| (is_nan(rsp.j_z) && rsp.j_z != CANON_NAN)))
		else $error("non-canonical NaN on result");

	a_stiff_mask: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PIPE_LAT-2] && mask_q && flag_d && mode_q == MODE_STIFF
		|=> done && rsp.j_x == NEG_ZERO && rsp.j_y == NEG_ZERO && rsp.j_z == NEG_ZERO)
		else $error("masked stiff-source point not negative zero");

endmodule
